@@ rtl/lpg_pkg.sv @@
// Shared constants and types for the line pixel generator.
`default_nettype none

package lpg_pkg;

  // Fixed field widths
  localparam int FIELD_BITS   = 16;
  localparam int COLOR_BITS   = 16;
  localparam int SIZE_BITS    = 11;
  localparam int CFG_IDX_BITS = 2;

  // Word modes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [SIZE_BITS-1:0] RESET_SCREEN_WIDTH  = 11'd240;
  localparam logic [SIZE_BITS-1:0] RESET_SCREEN_HEIGHT = 11'd320;

  // Flags that the step logic hands back to the top level
  typedef struct packed {
    logic pixel_valid;
    logic last_pixel;
    logic line_active;
    logic use_new_color;
  } step_flags_t;

endpackage

`default_nettype wire

@@ rtl/lpg_step.sv @@
// Combinational Bresenham step: endpoint clamp, line set-up and one walk step.
`default_nettype none

module lpg_step import lpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                   mode,
  input  wire logic [FIELD_BITS-1:0]  start_x,
  input  wire logic [FIELD_BITS-1:0]  start_y,
  input  wire logic [FIELD_BITS-1:0]  end_x,
  input  wire logic [FIELD_BITS-1:0]  end_y,
  input  wire logic [SIZE_BITS-1:0]   screen_width,
  input  wire logic [SIZE_BITS-1:0]   screen_height,
  // current line state
  input  wire logic [COORD_BITS-1:0]  cur_x,
  input  wire logic [COORD_BITS-1:0]  cur_y,
  input  wire logic [COORD_BITS-1:0]  target_x,
  input  wire logic [COORD_BITS-1:0]  target_y,
  input  wire logic [COORD_BITS-1:0]  abs_dx,
  input  wire logic [COORD_BITS-1:0]  abs_dy,
  input  wire logic                   x_step_negative,
  input  wire logic                   y_step_negative,
  input  wire logic signed [COORD_BITS+1:0] error_term,
  input  wire logic                   line_active,
  // next line state
  output logic [COORD_BITS-1:0]       cur_x_next,
  output logic [COORD_BITS-1:0]       cur_y_next,
  output logic [COORD_BITS-1:0]       target_x_next,
  output logic [COORD_BITS-1:0]       target_y_next,
  output logic [COORD_BITS-1:0]       abs_dx_next,
  output logic [COORD_BITS-1:0]       abs_dy_next,
  output logic                        x_step_negative_next,
  output logic                        y_step_negative_next,
  output logic signed [COORD_BITS+1:0] error_term_next,
  output step_flags_t                 flags
);

  localparam int LW = FIELD_BITS + 1;
  localparam int EW = COORD_BITS + 2;
  localparam logic [LW-1:0] COORD_MAX = LW'((1 << COORD_BITS) - 1);

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic [FIELD_BITS-1:0] v,
    input logic [SIZE_BITS-1:0]  size
  );
    logic [LW-1:0] lim;
    logic [LW-1:0] vx;
    vx  = LW'(v);
    lim = (size == '0) ? '0 : LW'(size - SIZE_BITS'(1));
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (vx > lim) vx = lim;
    return vx[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] x0, y0, x1, y1;
  logic                  xn0, yn0;
  logic [COORD_BITS-1:0] dx0, dy0;
  logic signed [EW-1:0]  err0;
  logic signed [EW-1:0]  sdx, sdy;
  logic                  move_x, move_y;
  logic [COORD_BITS-1:0] wx, wy;
  logic signed [EW-1:0]  werr;
  logic                  at_end_start, at_end_walk;

  // Start: clamp, deltas, initial error
  always_comb begin
    x0  = clamp_coord(start_x, screen_width);
    y0  = clamp_coord(start_y, screen_height);
    x1  = clamp_coord(end_x, screen_width);
    y1  = clamp_coord(end_y, screen_height);
    xn0 = x1 < x0;
    yn0 = y1 < y0;
    dx0 = xn0 ? x0 - x1 : x1 - x0;
    dy0 = yn0 ? y0 - y1 : y1 - y0;
    if (dx0 > dy0) begin
      err0 = $signed(EW'(dx0 >> 1));
    end else begin
      err0 = -$signed(EW'(dy0 >> 1));
    end
    at_end_start = (x0 == x1) && (y0 == y1);
  end

  // Walk: one step from the stored state
  always_comb begin
    sdx    = $signed(EW'(abs_dx));
    sdy    = $signed(EW'(abs_dy));
    move_x = error_term > -sdx;
    move_y = error_term < sdy;
    werr   = error_term - (move_x ? sdy : '0) + (move_y ? sdx : '0);
    wx     = cur_x;
    wy     = cur_y;
    if (move_x) wx = x_step_negative ? cur_x - 1'b1 : cur_x + 1'b1;
    if (move_y) wy = y_step_negative ? cur_y - 1'b1 : cur_y + 1'b1;
    at_end_walk = (wx == target_x) && (wy == target_y);
  end

  always_comb begin
    cur_x_next           = cur_x;
    cur_y_next           = cur_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    abs_dx_next          = abs_dx;
    abs_dy_next          = abs_dy;
    x_step_negative_next = x_step_negative;
    y_step_negative_next = y_step_negative;
    error_term_next      = error_term;
    flags                = '0;
    flags.line_active    = line_active;
    unique case (mode)
      MODE_START: begin
        cur_x_next           = x0;
        cur_y_next           = y0;
        target_x_next        = x1;
        target_y_next        = y1;
        abs_dx_next          = dx0;
        abs_dy_next          = dy0;
        x_step_negative_next = xn0;
        y_step_negative_next = yn0;
        error_term_next      = err0;
        flags.pixel_valid    = 1'b1;
        flags.last_pixel     = at_end_start;
        flags.line_active    = !at_end_start;
        flags.use_new_color  = 1'b1;
      end
      MODE_ADVANCE: begin
        if (line_active) begin
          cur_x_next        = wx;
          cur_y_next        = wy;
          error_term_next   = werr;
          flags.pixel_valid = 1'b1;
          flags.last_pixel  = at_end_walk;
          flags.line_active = !at_end_walk;
        end
      end
      default: begin
        flags.line_active = line_active;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/line_pixel_generator.sv @@
// Top level of the line pixel generator: Bresenham walker with registered output word.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid / in_stall | mode, start_x, start_y, end_x, end_y, line_color
//  out      | out_valid/out_stall | pixel_x, pixel_y, pixel_color, pixel_valid,
//           |                     | last_pixel
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One word in, one word out. An accepted word shows on the output in the next cycle;
// one word per clock is sustained while the output is not stalled, set by the single
// step path from the line state registers back to themselves.
// rst is synchronous: clears the line and out_valid and restores the screen size.
// in_stall is raised only while a finished word sits in the output register and the
// downstream side stalls it; otherwise a new word is taken in the same cycle the old
// one leaves.
`default_nettype none

module line_pixel_generator import lpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input words
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    mode,
  input  wire logic [FIELD_BITS-1:0]   start_x,
  input  wire logic [FIELD_BITS-1:0]   start_y,
  input  wire logic [FIELD_BITS-1:0]   end_x,
  input  wire logic [FIELD_BITS-1:0]   end_y,
  input  wire logic [COLOR_BITS-1:0]   line_color,
  // output words
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [COORD_BITS-1:0]        pixel_x,
  output logic [COORD_BITS-1:0]        pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         pixel_valid,
  output logic                         last_pixel,
  // configuration writes
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SIZE_BITS-1:0]    cfg_data
);

  // Screen size registers
  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  // Line state
  logic [COORD_BITS-1:0]        cur_x, cur_y, target_x, target_y;
  logic [COORD_BITS-1:0]        abs_dx, abs_dy;
  logic                         x_step_negative, y_step_negative;
  logic signed [COORD_BITS+1:0] error_term;
  logic [COLOR_BITS-1:0]        held_color;
  logic                         line_active;

  logic [COORD_BITS-1:0]        cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic [COORD_BITS-1:0]        abs_dx_next, abs_dy_next;
  logic                         x_step_negative_next, y_step_negative_next;
  logic signed [COORD_BITS+1:0] error_term_next;
  step_flags_t                  flags;
  logic [COLOR_BITS-1:0]        color_next;
  logic                         accept;

  // Input is held off only when the output word is full and stalled
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_SCREEN_WIDTH;
      screen_height <= RESET_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      // indexes past the register list are dropped
      if (cfg_index == CFG_SCREEN_WIDTH)  screen_width  <= cfg_data;
      if (cfg_index == CFG_SCREEN_HEIGHT) screen_height <= cfg_data;
    end
  end

  lpg_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .mode                 (mode),
    .start_x              (start_x),
    .start_y              (start_y),
    .end_x                (end_x),
    .end_y                (end_y),
    .screen_width         (screen_width),
    .screen_height        (screen_height),
    .cur_x                (cur_x),
    .cur_y                (cur_y),
    .target_x             (target_x),
    .target_y             (target_y),
    .abs_dx               (abs_dx),
    .abs_dy               (abs_dy),
    .x_step_negative      (x_step_negative),
    .y_step_negative      (y_step_negative),
    .error_term           (error_term),
    .line_active          (line_active),
    .cur_x_next           (cur_x_next),
    .cur_y_next           (cur_y_next),
    .target_x_next        (target_x_next),
    .target_y_next        (target_y_next),
    .abs_dx_next          (abs_dx_next),
    .abs_dy_next          (abs_dy_next),
    .x_step_negative_next (x_step_negative_next),
    .y_step_negative_next (y_step_negative_next),
    .error_term_next      (error_term_next),
    .flags                (flags)
  );

  // A start takes the new colour; the rest of a line keeps the held one
  assign color_next = flags.use_new_color ? line_color : held_color;

  // Line state: control bit reset, payload updated on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept) begin
      line_active <= flags.line_active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x           <= cur_x_next;
      cur_y           <= cur_y_next;
      target_x        <= target_x_next;
      target_y        <= target_y_next;
      abs_dx          <= abs_dx_next;
      abs_dy          <= abs_dy_next;
      x_step_negative <= x_step_negative_next;
      y_step_negative <= y_step_negative_next;
      error_term      <= error_term_next;
      held_color      <= color_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // an advance with no line gives an all-zero word
      pixel_x     <= flags.pixel_valid ? cur_x_next : '0;
      pixel_y     <= flags.pixel_valid ? cur_y_next : '0;
      pixel_color <= flags.pixel_valid ? color_next : '0;
      pixel_valid <= flags.pixel_valid;
      last_pixel  <= flags.last_pixel;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpg_checker.sv @@
// Port-level checks for the line pixel generator, bound to the top level.
`default_nettype none

module lpg_checker import lpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] pixel_x,
  input wire logic [COORD_BITS-1:0] pixel_y,
  input wire logic [COLOR_BITS-1:0] pixel_color,
  input wire logic                  pixel_valid,
  input wire logic                  last_pixel
);

  // Every accepted word yields an output word on the next cycle
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no output word");

  // Input is held off only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid && out_stall) && !$past(rst) |->
      $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) &&
      $stable(pixel_valid) && $stable(last_pixel))
    else $error("stalled output word changed");

  // No line: the word carries zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |->
      pixel_x == '0 && pixel_y == '0 && pixel_color == '0 && !last_pixel)
    else $error("word without pixel carries data");

  // End of line only on a real pixel
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> pixel_valid)
    else $error("last flag on a word without pixel");

endmodule

bind line_pixel_generator lpg_checker #(
  .COORD_BITS (COORD_BITS)
) u_lpg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .pixel_valid (pixel_valid),
  .last_pixel  (last_pixel)
);

`default_nettype wire

@@ bench/line_pixel_generator_tb.sv @@
// Self-checking testbench for the Bresenham line pixel generator.
`default_nettype none

module line_pixel_generator_tb;
  import lpg_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int CYCLE_LIMIT = 300000;

  // register indexes past the two real ones; the block must ignore these writes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  // one input word
  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] sx;
    logic [FIELD_BITS-1:0] sy;
    logic [FIELD_BITS-1:0] ex;
    logic [FIELD_BITS-1:0] ey;
    logic [COLOR_BITS-1:0] colour;
  } line_word_t;

  // one output word
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] colour;
    logic                  valid;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic mode;
  logic [FIELD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [COLOR_BITS-1:0] line_color;
  logic out_valid;
  logic out_stall;
  logic [COORD_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic pixel_valid, last_pixel;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0] cfg_data;

  line_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_color  (line_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  pixel_t pixel_q[$];      // pixels still owed by the block, oldest first
  int     errors = 0;
  int     cycle_count = 0;
  int     hold_cycles = 0; // >0 asks the stall process for one long hold-off
  bit     idle_on = 1'b1;  // random gaps on both channels

  // Predictor copy of the screen size and the line walker
  logic [SIZE_BITS-1:0]  scr_w, scr_h;
  logic [COORD_BITS-1:0] walk_x, walk_y, goal_x, goal_y;
  int                    run_x, run_y;    // absolute deltas
  logic                  x_back, y_back;  // step towards smaller coordinate
  int                    err_acc;
  logic [COLOR_BITS-1:0] line_colour;
  logic                  line_live;

  // Size 0 behaves as 1; the limit saturates at the top of the coordinate range.
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(logic [FIELD_BITS-1:0] v,
                                                            logic [SIZE_BITS-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (int'(v) > lim) return lim[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  // Advances the predictor by one word and returns the pixel it should produce.
  function automatic pixel_t next_pixel(line_word_t w);
    pixel_t p;
    int e;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic at_end;
    p = '0;
    if (w.mode == MODE_START) begin
      x0 = clamp_to_screen(w.sx, scr_w);
      y0 = clamp_to_screen(w.sy, scr_h);
      x1 = clamp_to_screen(w.ex, scr_w);
      y1 = clamp_to_screen(w.ey, scr_h);
      walk_x = x0;
      walk_y = y0;
      goal_x = x1;
      goal_y = y1;
      x_back = x1 < x0;
      y_back = y1 < y0;
      run_x = x_back ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
      run_y = y_back ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
      err_acc = (run_x > run_y) ? run_x / 2 : -(run_y / 2);
      line_colour = w.colour;
      at_end = (x0 == x1) && (y0 == y1);
      line_live = !at_end;
    end else if (!line_live) begin
      return p;  // no line: an empty word, all fields zero
    end else begin
      e = err_acc;
      if (e > -run_x) begin
        err_acc -= run_y;
        walk_x = x_back ? walk_x - 1'b1 : walk_x + 1'b1;
      end
      if (e < run_y) begin
        err_acc += run_x;
        walk_y = y_back ? walk_y - 1'b1 : walk_y + 1'b1;
      end
      at_end = (walk_x == goal_x) && (walk_y == goal_y);
      if (at_end) line_live = 1'b0;
    end
    p.x = walk_x;
    p.y = walk_y;
    p.colour = line_colour;
    p.valid = 1'b1;
    p.last = at_end;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic line_word_t start_word(logic [15:0] sx, logic [15:0] sy,
                                            logic [15:0] ex, logic [15:0] ey,
                                            logic [15:0] colour);
    line_word_t w;
    w.mode = MODE_START;
    w.sx = sx;
    w.sy = sy;
    w.ex = ex;
    w.ey = ey;
    w.colour = colour;
    return w;
  endfunction

  // payload of an advance word is junk on purpose; the block must ignore it
  function automatic line_word_t advance_word();
    line_word_t w;
    w = start_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    w.mode = MODE_ADVANCE;
    return w;
  endfunction

  function automatic logic [15:0] pick_coord(logic [SIZE_BITS-1:0] size);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, size));
  endfunction

  function automatic logic [15:0] near_coord(logic [15:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Offers one word and returns once it has been taken. valid stays high between
  // back-to-back words; only a random gap drops it.
  task automatic send_word(input line_word_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= w.mode;
    start_x    <= w.sx;
    start_y    <= w.sy;
    end_x      <= w.ex;
    end_y      <= w.ey;
    line_color <= w.colour;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(next_pixel(w));
  endtask

  // start word plus a number of advance words
  task automatic draw_line(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] ex, input logic [15:0] ey,
                           input logic [15:0] colour, input int steps);
    send_word(start_word(sx, sy, ex, ey, colour));
    repeat (steps) send_word(advance_word());
  endtask

  // Sender goes quiet until every owed pixel is back, then a few spare cycles.
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_screen_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [SIZE_BITS-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SCREEN_WIDTH) scr_w = value;
    else if (idx == CFG_SCREEN_HEIGHT) scr_h = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : stall_ctl
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: every word taken off the output is matched against the oldest
  // owed pixel, field by field
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: output word with none expected, got x=%0d y=%0d", $time,
                 pixel_x, pixel_y);
      end else begin
        want = pixel_q.pop_front();
        compare_field("pixel_x", 16'(want.x), 16'(pixel_x));
        compare_field("pixel_y", 16'(want.y), 16'(pixel_y));
        compare_field("pixel_color", want.colour, pixel_color);
        compare_field("pixel_valid", 16'(want.valid), 16'(pixel_valid));
        compare_field("last_pixel", 16'(want.last), 16'(last_pixel));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty advances, single-point lines at both ends of the field range, and a
  // restart in the middle of a line.
  task automatic test_points_and_restart();
    send_word(advance_word());                                // nothing drawn yet
    draw_line(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
    send_word(advance_word());                                // line already done
    draw_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    draw_line(0, 7, 5, 7, 16'hF800, 2);                       // horizontal, cut short
    draw_line(3, 0, 3, 3, 16'h07E0, 4);                       // vertical, restart above
  endtask

  // One short line into each octant from a common centre.
  task automatic test_octants();
    int ox[8] = '{2, 1, -1, -2, -2, -1, 1, 2};
    int oy[8] = '{1, 2, 2, 1, -1, -2, -2, -1};
    for (int i = 0; i < 8; i++)
      draw_line(20, 20, 16'(20 + ox[i]), 16'(20 + oy[i]), 16'($urandom), 2);
  endtask

  // Size registers: zero, oversize, spare indexes, and a write while a line runs.
  task automatic test_screen_sizes();
    write_screen_reg(CFG_SCREEN_WIDTH, 11'd0);
    write_screen_reg(CFG_SCREEN_HEIGHT, 11'h7FF);
    draw_line(700, 1020, 9, 16'hFFFF, 16'h001F, 3);    // x pinned at 0, y saturates
    write_screen_reg(CFG_SPARE_LO, 11'd5);
    write_screen_reg(CFG_SPARE_HI, 11'd7);
    draw_line(16'hFFFF, 16'hFFFF, 40, 1023, 16'hAAAA, 1);  // sizes must be unchanged
    write_screen_reg(CFG_SCREEN_WIDTH, 11'd1024);
    write_screen_reg(CFG_SCREEN_HEIGHT, 11'd1024);
    draw_line(1013, 100, 1023, 104, 16'h5555, 3);
    // the running line keeps its endpoints across a resize
    write_screen_reg(CFG_SCREEN_WIDTH, 11'd1);
    write_screen_reg(CFG_SCREEN_HEIGHT, 11'd1);
    repeat (8) send_word(advance_word());
    draw_line(50, 50, 60, 60, 16'h1234, 1);              // collapses to one pixel
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses.
  task automatic test_backpressure();
    write_screen_reg(CFG_SCREEN_WIDTH, 11'd240);
    write_screen_reg(CFG_SCREEN_HEIGHT, 11'd320);
    hold_cycles = 60;
    draw_line(10, 300, 200, 250, 16'hC0DE, 40);
    drain();
    draw_line(200, 10, 190, 40, 16'hBEEF, 30);
  endtask

  // Mostly complete lines with random ends; some abandoned early, some walked
  // past the end, and some loose words.
  task automatic test_random_lines(input logic [SIZE_BITS-1:0] w,
                                   input logic [SIZE_BITS-1:0] h, input int budget);
    int sent;
    int span, dxa, dya, steps, kind;
    logic [15:0] sx, sy, ex, ey;
    write_screen_reg(CFG_SCREEN_WIDTH, w);
    write_screen_reg(CFG_SCREEN_HEIGHT, h);
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        if ($urandom_range(0, 1) == 0) send_word(advance_word());
        else send_word(start_word(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom)));
        sent++;
      end else begin
        sx = pick_coord(scr_w);
        sy = pick_coord(scr_h);
        ex = ($urandom_range(0, 5) == 0) ? pick_coord(scr_w) : near_coord(sx, 12);
        ey = ($urandom_range(0, 5) == 0) ? pick_coord(scr_h) : near_coord(sy, 12);
        dxa = int'(clamp_to_screen(ex, scr_w)) - int'(clamp_to_screen(sx, scr_w));
        dya = int'(clamp_to_screen(ey, scr_h)) - int'(clamp_to_screen(sy, scr_h));
        if (dxa < 0) dxa = -dxa;
        if (dya < 0) dya = -dya;
        span = (dxa > dya) ? dxa : dya;
        if (kind == 1 && span > 0) steps = $urandom_range(0, span - 1);
        else if (kind == 2) steps = span + $urandom_range(1, 3);
        else steps = span;
        // long lines are mostly cut short to keep the run brisk
        if (steps > 64 && $urandom_range(0, 3) != 0) steps = $urandom_range(1, 64);
        draw_line(sx, sy, ex, ey, 16'($urandom), steps);
        sent += steps + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= MODE_START;
    start_x    <= '0;
    start_y    <= '0;
    end_x      <= '0;
    end_y      <= '0;
    line_color <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SCREEN_WIDTH;
    cfg_data   <= '0;
    scr_w = RESET_SCREEN_WIDTH;
    scr_h = RESET_SCREEN_HEIGHT;
    walk_x = '0;
    walk_y = '0;
    goal_x = '0;
    goal_y = '0;
    run_x = 0;
    run_y = 0;
    x_back = 1'b0;
    y_back = 1'b0;
    err_acc = 0;
    line_colour = '0;
    line_live = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_points_and_restart();
    test_octants();
    test_screen_sizes();
    test_backpressure();
    test_random_lines(11'd240, 11'd320, 300);
    test_random_lines(11'd1024, 11'd1024, 300);
    test_random_lines(11'd1, 11'd1024, 200);
    test_random_lines(11'd1024, 11'd1, 200);
    test_random_lines(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), 300);
    idle_on = 1'b0;  // final stretch at full rate
    test_random_lines(11'd64, 11'd48, 300);

    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
